// ----- rtl/sgmr_pkg.sv -----
package sgmr_pkg;

  localparam int NUM_REGS = 8;

  // register indexes of the factor file
  localparam int unsigned REG_DIFF_R  = 0;
  localparam int unsigned REG_DIFF_G  = 1;
  localparam int unsigned REG_DIFF_B  = 2;
  localparam int unsigned REG_DIFF_A  = 3;
  localparam int unsigned REG_SPEC_R  = 4;
  localparam int unsigned REG_SPEC_G  = 5;
  localparam int unsigned REG_SPEC_B  = 6;
  localparam int unsigned REG_GLOSS   = 7;

  localparam logic [15:0] FAC_RESET = 16'd32768;
  localparam logic [7:0]  OCC_BYTE  = 8'd255;

  // pipeline levels per unit
  localparam int FE_LV = 3;
  localparam int MT_LV = 10;
  localparam int BL_LV = 4;
  localparam int SQ_ST = 5;
  localparam int ALL_LV = FE_LV + MT_LV + BL_LV;

  localparam int SC_W   = 17;
  localparam int B_W    = 20;
  localparam int RAD_W  = 38;
  localparam int ROOT_W = 19;
  localparam int M_W    = 17;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] DARK_LIM = 17'd2622;   // smax*25 < 1.0
  localparam logic [19:0] B_OFS    = 20'd5243;   // 0.08 in Q16
  localparam logic [39:0] D_OFS    = 40'd27487790;

  // reciprocal multipliers: floor(v/d) = (v*K) >> S over the ranges used
  localparam logic [25:0] K_DIV3   = 26'd22369622;
  localparam int          S_DIV3   = 26;
  localparam logic [25:0] K_DIV25  = 26'd42949673;
  localparam int          S_DIV25  = 30;
  localparam logic [25:0] K_DIV255 = 26'd33686019;
  localparam int          S_DIV255 = 33;
  localparam logic [17:0] K_Q25    = 18'd167773;
  localparam int          S_Q25    = 22;

  typedef logic [255:0][16:0] lin_lut_t;
  typedef logic [24:0][17:0]  r25_tab_t;
  typedef logic [NUM_REGS-1:0][15:0] fac_arr_t;

  typedef struct packed {
    logic [2:0][7:0] dif;
    logic [7:0]      dif_alpha;
    logic [2:0][7:0] spc;
    logic [7:0]      gloss;
  } pix_t;

  typedef struct packed {
    logic [2:0][SC_W-1:0] sl;
    logic [7:0]           alpha;
    logic [7:0]           rough;
  } carry_t;

  typedef struct packed {
    logic [2:0][SC_W-1:0] dl;
    logic [SC_W-1:0]      dmax;
    logic [SC_W-1:0]      smax;
    carry_t               car;
  } front_t;

  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic                  zero;
    logic [2:0][39:0]      p;
    carry_t                car;
  } sq_side_t;

  typedef struct packed {
    logic [M_W-1:0]   m;
    logic [2:0][39:0] p;
    carry_t           car;
  } metal_t;

  typedef struct packed {
    logic [2:0][7:0] base;
    logic [7:0]      alpha;
    logic [7:0]      rough;
    logic [7:0]      metal;
  } res_t;

  // sRGB byte to linear Q16, fifth-root search in Q30
  function automatic lin_lut_t build_lin_lut();
    lin_lut_t t;
    longint unsigned x, x2, z, cand, z2, z4, p5, y;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        t[c] = 17'((64'(c) * 64'd655360 + 64'd16473) / 64'd32946);
      end else begin
        x = (64'(1000 * c + 14025) << 30) / 64'd269025;
        x2 = (x * x) >> 30;
        z = 64'd0;
        for (int bt = 30; bt >= 0; bt--) begin
          cand = z | (64'd1 << bt);
          z2 = (cand * cand) >> 30;
          z4 = (z2 * z2) >> 30;
          p5 = (z4 * cand) >> 30;
          if (cand <= (64'd1 << 30) && p5 <= x2) z = cand;
        end
        y = (x2 * z) >> 30;
        t[c] = 17'((y + 64'd8192) >> 14);
      end
    end
    return t;
  endfunction

  // floor(r * 2^18 / 25) for remainders of a division by 25
  function automatic r25_tab_t build_r25_tab();
    r25_tab_t t;
    for (int r = 0; r < 25; r++) begin
      t[r] = 18'((r * 262144) / 25);
    end
    return t;
  endfunction

  function automatic logic [7:0] to_byte(input logic signed [26:0] v);
    logic [16:0] c;
    logic [24:0] p;
    if (v < 0) c = 17'd0;
    else if (v > 27'sd65536) c = ONE_Q16;
    else c = v[16:0];
    p = {c, 8'b0} - 25'(c);
    return 8'((p + 25'd32768) >> 16);
  endfunction

endpackage

// ----- rtl/specgloss_to_metalrough_pixel.sv -----
// Specular-glossiness to metallic-roughness pixel converter. Each item is one
// diffuse RGBA texel plus one specular-glossiness texel (feed all-255 texels
// for an absent image) and yields one pixel: linear base RGBA, occlusion fixed
// at 255, roughness and metallic, all as rounded bytes. The pipeline is 17
// register levels deep; one item is taken every cycle while out_ready
// is high. A stall at the output closes up bubbles level by level, so in_ready
// only drops once every level holds an item. The depth comes from the metallic
// solve: the discriminant's square root takes five levels of four root bits
// each but the last, which takes three, and the wide blend products are split
// over two levels. The eight Q1.15 factor registers (32768 = 1.0 after reset)
// are to be written by the user through the cfg channel only between bursts,
// with the pipeline drained; the block does not enforce this. Indexes beyond
// seven are ignored.
module specgloss_to_metalrough_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_diffuse_red,
  input  logic [7:0]  in_diffuse_green,
  input  logic [7:0]  in_diffuse_blue,
  input  logic [7:0]  in_diffuse_alpha,
  input  logic [7:0]  in_spec_red,
  input  logic [7:0]  in_spec_green,
  input  logic [7:0]  in_spec_blue,
  input  logic [7:0]  in_gloss_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_base_red,
  output logic [7:0]  out_base_green,
  output logic [7:0]  out_base_blue,
  output logic [7:0]  out_base_alpha,
  output logic [7:0]  out_occlusion_out,
  output logic [7:0]  out_roughness_out,
  output logic [7:0]  out_metallic_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sgmr_pkg::*;

  fac_arr_t          fac_r;
  logic [ALL_LV-1:0] v_r;
  logic [ALL_LV-1:0] en;
  pix_t              pix;
  front_t            fo;
  metal_t            mo;
  res_t              ro;

  // factor register file; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        fac_r[i] <= FAC_RESET;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < 8'(NUM_REGS))) begin
      fac_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // a level advances when it is empty or the level after it advances
  assign en[ALL_LV-1] = !v_r[ALL_LV-1] | out_ready;
  for (genvar k = 0; k < ALL_LV - 1; k++) begin : g_en
    assign en[k] = !v_r[k] | en[k+1];
  end

  assign in_ready = en[0];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < ALL_LV; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign pix.dif[0]    = in_diffuse_red;
  assign pix.dif[1]    = in_diffuse_green;
  assign pix.dif[2]    = in_diffuse_blue;
  assign pix.dif_alpha = in_diffuse_alpha;
  assign pix.spc[0]    = in_spec_red;
  assign pix.spc[1]    = in_spec_green;
  assign pix.spc[2]    = in_spec_blue;
  assign pix.gloss     = in_gloss_byte;

  // linearise, scale and take channel maxima
  sgmr_front u_front (
    .clk (clk),
    .en  (en[FE_LV-1:0]),
    .fac (fac_r),
    .pix (pix),
    .fo  (fo)
  );

  // solve the quadratic for metallic
  sgmr_metal u_metal (
    .clk (clk),
    .en  (en[FE_LV+MT_LV-1:FE_LV]),
    .fi  (fo),
    .mo  (mo)
  );

  // blend diffuse and specular estimates, round to bytes
  sgmr_blend u_blend (
    .clk (clk),
    .en  (en[ALL_LV-1:FE_LV+MT_LV]),
    .mi  (mo),
    .ro  (ro)
  );

  assign out_valid         = v_r[ALL_LV-1];
  assign out_base_red      = ro.base[0];
  assign out_base_green    = ro.base[1];
  assign out_base_blue     = ro.base[2];
  assign out_base_alpha    = ro.alpha;
  assign out_occlusion_out = OCC_BYTE;
  assign out_roughness_out = ro.rough;
  assign out_metallic_out  = ro.metal;

  // input is refused only when every level is occupied
  a_full_when_refused: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("in_ready low with a bubble in the pipeline");

  // a stalled first level keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !en[0]) |=> v_r[0])
    else $error("stalled item dropped at the first level");

  // with the output blocked no item may vanish inside
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($countones(v_r) >= $past($countones(v_r))))
    else $error("item lost while the output was stalled");

endmodule

// ----- rtl/sgmr_front.sv -----
module sgmr_front (
  input  logic              clk,
  input  logic [2:0]        en,
  input  sgmr_pkg::fac_arr_t fac,
  input  sgmr_pkg::pix_t    pix,
  output sgmr_pkg::front_t  fo
);
  import sgmr_pkg::*;

  localparam lin_lut_t LinLut = build_lin_lut();

  logic [2:0][16:0] lin_d_r, lin_s_r;
  logic [23:0]      gm_r;
  logic [7:0]       alpha0_r, alpha1_r;
  logic [23:0]      am;
  logic [8:0]       a9;
  logic [24:0]      gnum;
  logic [50:0]      gprod;
  logic [2:0][SC_W-1:0] dl_nxt, sl_nxt, dl1_r, sl1_r;
  logic [SC_W-1:0]  gloss_nxt, gloss_r;
  logic [SC_W-1:0]  dmax_nxt, smax_nxt;
  logic [7:0]       rough_nxt;
  front_t           fo_r;

  // level 0: table lookups, alpha and glossiness products
  always_comb begin
    am = pix.dif_alpha * fac[REG_DIFF_A];
    a9 = 9'((am + 24'd16384) >> 15);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        lin_d_r[i] <= LinLut[pix.dif[i]];
        lin_s_r[i] <= LinLut[pix.spc[i]];
      end
      gm_r     <= pix.gloss * fac[REG_GLOSS];
      alpha0_r <= (a9 > 9'd255) ? 8'd255 : a9[7:0];
    end
  end

  // level 1: apply factors, divide glossiness by 255
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dl_nxt[i] = SC_W'((34'(lin_d_r[i] * fac[REG_DIFF_R + i]) + 34'd16384) >> 15);
      sl_nxt[i] = SC_W'((34'(lin_s_r[i] * fac[REG_SPEC_R + i]) + 34'd16384) >> 15);
    end
    gnum  = {gm_r, 1'b0} + 25'd127;
    gprod = gnum * K_DIV255;
    gloss_nxt = SC_W'(gprod >> S_DIV255);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dl1_r    <= dl_nxt;
      sl1_r    <= sl_nxt;
      gloss_r  <= gloss_nxt;
      alpha1_r <= alpha0_r;
    end
  end

  // level 2: channel maxima, roughness byte
  always_comb begin
    dmax_nxt = (dl1_r[0] > dl1_r[1]) ? dl1_r[0] : dl1_r[1];
    if (dl1_r[2] > dmax_nxt) dmax_nxt = dl1_r[2];
    smax_nxt = (sl1_r[0] > sl1_r[1]) ? sl1_r[0] : sl1_r[1];
    if (sl1_r[2] > smax_nxt) smax_nxt = sl1_r[2];
    rough_nxt = to_byte(27'sd65536 - $signed({10'b0, gloss_r}));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fo_r.dl        <= dl1_r;
      fo_r.dmax      <= dmax_nxt;
      fo_r.smax      <= smax_nxt;
      fo_r.car.sl    <= sl1_r;
      fo_r.car.alpha <= alpha1_r;
      fo_r.car.rough <= rough_nxt;
    end
  end

  assign fo = fo_r;

endmodule

// ----- rtl/sgmr_sqrt.sv -----
module sgmr_sqrt (
  input  logic                      clk,
  input  logic [sgmr_pkg::SQ_ST-1:0] en,
  input  logic [sgmr_pkg::RAD_W-1:0] rad,
  input  sgmr_pkg::sq_side_t        side_i,
  output logic [sgmr_pkg::ROOT_W-1:0] root,
  output sgmr_pkg::sq_side_t        side_o
);
  import sgmr_pkg::*;

  logic [SQ_ST-1:0][RAD_W-1:0]  rem_r;
  logic [SQ_ST-1:0][ROOT_W-1:0] root_r;
  sq_side_t                     side_r [SQ_ST];

  // four root bits per level (three at the last), restoring digit recurrence
  for (genvar gs = 0; gs < SQ_ST; gs++) begin : g_st
    localparam int Hi = ROOT_W - 1 - 4 * gs;
    localparam int Lo = (Hi - 3 > 0) ? Hi - 3 : 0;
    logic [RAD_W-1:0]  rem_in, rem_nxt;
    logic [ROOT_W-1:0] rt_in, rt_nxt;
    sq_side_t          sd_in;

    if (gs == 0) begin : g_first
      assign rem_in = rad;
      assign rt_in  = '0;
      assign sd_in  = side_i;
    end else begin : g_next
      assign rem_in = rem_r[gs-1];
      assign rt_in  = root_r[gs-1];
      assign sd_in  = side_r[gs-1];
    end

    always_comb begin
      logic [RAD_W-1:0] t;
      rem_nxt = rem_in;
      rt_nxt  = rt_in;
      for (int i = Hi; i >= Lo; i--) begin
        t = (RAD_W'(rt_nxt) << (i + 1)) | (RAD_W'(1) << (2 * i));
        if (rem_nxt >= t) begin
          rem_nxt   = rem_nxt - t;
          rt_nxt[i] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[gs]) begin
        rem_r[gs]  <= rem_nxt;
        root_r[gs] <= rt_nxt;
        side_r[gs] <= sd_in;
      end
    end
  end

  assign root   = root_r[SQ_ST-1];
  assign side_o = side_r[SQ_ST-1];

endmodule

// ----- rtl/sgmr_metal.sv -----
module sgmr_metal (
  input  logic                       clk,
  input  logic [sgmr_pkg::MT_LV-1:0] en,
  input  sgmr_pkg::front_t           fi,
  output sgmr_pkg::metal_t           mo
);
  import sgmr_pkg::*;

  localparam r25_tab_t R25Tab = build_r25_tab();

  // level 0
  logic signed [17:0]      om;
  logic signed [35:0]      pb_r;
  logic [2:0][35:0]        pd_r;
  logic [12:0]             q1_r;
  logic [SC_W-1:0]         smax0_r, smax1_r;
  logic                    dark0_r, dark1_r, dark2_r;
  carry_t                  car0_r, car1_r, car2_r;
  // level 1
  logic signed [39:0]      n;
  logic [39:0]             an;
  logic [4:0]              r1;
  logic [20:0]             v_r;
  logic                    bneg_r;
  logic [30:0]             t1_r, t2_r;
  logic [2:0][39:0]        p1_r, p2_r;
  // level 2
  logic [17:0]             bq;
  logic signed [B_W-1:0]   b_nxt, b_r;
  // level 3
  logic signed [39:0]      d;
  logic [RAD_W-1:0]        rad_r;
  sq_side_t                side3_r, side_o;
  logic [ROOT_W-1:0]       root;
  // last level
  logic signed [20:0]      diff;
  logic signed [25:0]      n25, h;
  logic [M_W-1:0]          m_nxt;
  metal_t                  mo_r;

  always_comb begin
    om = 18'sd65536 - $signed({1'b0, fi.smax});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pb_r <= $signed({1'b0, fi.dmax}) * om;
      for (int i = 0; i < 3; i++) begin
        pd_r[i] <= $signed({1'b0, fi.dl[i]}) * om;
      end
      q1_r    <= 13'((35'(fi.smax) * 35'(K_Q25)) >> S_Q25);
      smax0_r <= fi.smax;
      dark0_r <= fi.smax < DARK_LIM;
      car0_r  <= fi.car;
    end
  end

  // level 1: b numerator, remainder split of smax*2^18/25
  always_comb begin
    n  = 40'(pb_r) * 40'sd25;
    an = n[39] ? 40'(-n) : 40'(n);
    r1 = 5'(18'(smax0_r) - 18'(q1_r * 5'd25));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v_r     <= 21'((an + 40'd786432) >> 19);
      bneg_r  <= n[39];
      t1_r    <= {q1_r, 18'b0} + 31'(R25Tab[r1]);
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= 40'($signed(40'($signed(pd_r[i])) * 40'sd25));
      end
      smax1_r <= smax0_r;
      dark1_r <= dark0_r;
      car1_r  <= car0_r;
    end
  end

  // level 2: finish the rounded divide by 24, form b
  always_comb begin
    bq    = 18'((47'(v_r) * 47'(K_DIV3)) >> S_DIV3);
    b_nxt = (bneg_r ? -$signed({2'b0, bq}) : $signed({2'b0, bq}))
            + $signed({3'b0, smax1_r}) - $signed(B_OFS);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      b_r     <= b_nxt;
      t2_r    <= t1_r;
      p2_r    <= p1_r;
      dark2_r <= dark1_r;
      car2_r  <= car1_r;
    end
  end

  // level 3: discriminant
  always_comb begin
    d = 40'(b_r * b_r) - $signed(D_OFS) + $signed({9'b0, t2_r});
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rad_r        <= d[RAD_W-1:0];
      side3_r.b    <= b_r;
      side3_r.zero <= dark2_r | d[39];
      side3_r.p    <= p2_r;
      side3_r.car  <= car2_r;
    end
  end

  sgmr_sqrt u_sqrt (
    .clk    (clk),
    .en     (en[3+SQ_ST:4]),
    .rad    (rad_r),
    .side_i (side3_r),
    .root   (root),
    .side_o (side_o)
  );

  // last level: m = (root - b) * 12.5, rounded and clamped
  always_comb begin
    diff = $signed({2'b0, root}) - $signed({side_o.b[B_W-1], side_o.b});
    n25  = 26'(diff) * 26'sd25;
    if (!n25[25]) h = (n25 + 26'sd1) >>> 1;
    else h = -((-n25 + 26'sd1) >>> 1);
    if (side_o.zero || h < 0) m_nxt = '0;
    else if (h > 26'sd65536) m_nxt = ONE_Q16;
    else m_nxt = h[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[MT_LV-1]) begin
      mo_r.m   <= m_nxt;
      mo_r.p   <= side_o.p;
      mo_r.car <= side_o.car;
    end
  end

  assign mo = mo_r;

endmodule

// ----- rtl/sgmr_blend.sv -----
module sgmr_blend (
  input  logic                       clk,
  input  logic [sgmr_pkg::BL_LV-1:0] en,
  input  sgmr_pkg::metal_t           mi,
  output sgmr_pkg::res_t             ro
);
  import sgmr_pkg::*;

  logic [17:0]             mm;
  logic [16:0]             omm;
  logic [2:0][21:0]        s25;
  logic [2:0][38:0]        prl_r;
  logic [2:0][37:0]        prh_r;
  logic [2:0][40:0]        sp_r;
  logic                    mfull0_r, mfull1_r, mfull2_r;
  logic [M_W-1:0]          m0_r, m1_r, m2_r;
  carry_t                  car0_r, car1_r, car2_r;
  logic signed [57:0]      dn [3];
  logic [57:0]             ad [3];
  logic [40:0]             asp [3];
  logic [2:0][22:0]        vd_r;
  logic [2:0][24:0]        vs_r;
  logic [2:0]              dneg_r, sneg_r;
  logic [20:0]             dq [3];
  logic [23:0]             sq [3];
  logic signed [26:0]      dterm [3];
  logic signed [26:0]      sterm [3];
  logic [2:0][26:0]        sum_r;
  res_t                    ro_r;

  // level 0: split products for the diffuse term, specular product
  always_comb begin
    mm  = 18'(mi.m) + 18'(ONE_Q16);
    omm = ONE_Q16 - mi.m;
    for (int i = 0; i < 3; i++) begin
      s25[i] = 22'(mi.car.sl[i]) * 22'd25;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        prl_r[i] <= 39'(mi.p[i][20:0] * mm);
        prh_r[i] <= 38'($signed(mi.p[i][39:21]) * $signed({1'b0, mm}));
        sp_r[i]  <= 41'(($signed({1'b0, s25[i]}) - $signed({6'b0, omm}))
                        * $signed({1'b0, mi.m}));
      end
      mfull0_r <= mi.m == ONE_Q16;
      m0_r     <= mi.m;
      car0_r   <= mi.car;
    end
  end

  // level 1: recombine, take magnitudes and add the rounding half
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i]  = (58'($signed(prh_r[i])) <<< 21) + $signed({19'b0, prl_r[i]});
      ad[i]  = dn[i][57] ? 58'(-dn[i]) : 58'(dn[i]);
      asp[i] = sp_r[i][40] ? 41'(-$signed(sp_r[i])) : sp_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        vd_r[i]   <= 23'((ad[i] + 58'd51539607552) >> 35);
        vs_r[i]   <= 25'((asp[i] + 41'd819200) >> 16);
        dneg_r[i] <= dn[i][57];
        sneg_r[i] <= sp_r[i][40];
      end
      mfull1_r <= mfull0_r;
      m1_r     <= m0_r;
      car1_r   <= car0_r;
    end
  end

  // level 2: divide by 3 and by 25, restore signs, sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dq[i] = 21'((49'(vd_r[i]) * 49'(K_DIV3)) >> S_DIV3);
      sq[i] = 24'((51'(vs_r[i]) * 51'(K_DIV25)) >> S_DIV25);
      if (mfull1_r) dterm[i] = '0;
      else if (dneg_r[i]) dterm[i] = -$signed({6'b0, dq[i]});
      else dterm[i] = $signed({6'b0, dq[i]});
      sterm[i] = sneg_r[i] ? -$signed({3'b0, sq[i]}) : $signed({3'b0, sq[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= dterm[i] + sterm[i];
      end
      mfull2_r <= mfull1_r;
      m2_r     <= m1_r;
      car2_r   <= car1_r;
    end
  end

  // level 3: output register
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        ro_r.base[i] <= to_byte($signed(sum_r[i]));
      end
      ro_r.alpha <= car2_r.alpha;
      ro_r.rough <= car2_r.rough;
      ro_r.metal <= mfull2_r ? 8'd255 : to_byte($signed({10'b0, m2_r}));
    end
  end

  assign ro = ro_r;

endmodule

// ----- sim/tb_specgloss_to_metalrough_pixel.sv -----
`timescale 1ns / 1ps

module tb_specgloss_to_metalrough_pixel;
  import sgmr_pkg::*;

  localparam int LATENCY   = 17;
  localparam int WDOG_MAX  = 20000;
  localparam int CFG_BAD   = 8;     // first index outside the factor file

  typedef struct {
    logic [7:0] dr, dg, db, da, sr, sg, sb, gl;
  } texel_t;

  typedef struct {
    logic [7:0] br, bg, bb, ba, occ, rough, metal;
  } pixel_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [7:0] in_diffuse_red, in_diffuse_green, in_diffuse_blue, in_diffuse_alpha;
  logic [7:0] in_spec_red, in_spec_green, in_spec_blue, in_gloss_byte;
  logic out_valid, out_ready;
  logic [7:0] out_base_red, out_base_green, out_base_blue, out_base_alpha;
  logic [7:0] out_occlusion_out, out_roughness_out, out_metallic_out;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;

  // shadow of the factor file, updated on each accepted write
  logic [15:0] factor [NUM_REGS];
  longint      srgb_to_lin [256];
  pixel_t      pending_pixels [$];

  int  mismatches;
  int  idle_cycles;
  bit  timed_out;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_output;

  specgloss_to_metalrough_pixel i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint mq30(longint unsigned a, longint unsigned b);
    return longint'((a * b) >> 30);
  endfunction

  // linearise one sRGB byte to Q16 by a bitwise fifth-root search
  function automatic longint linearise(int c);
    longint unsigned x, x2, z, cand, p;
    if (c <= 10) return (longint'(c) * 655360 + 16473) / 32946;
    x  = (longint'(1000 * c + 14025) << 30) / 269025;
    x2 = mq30(x, x);
    z  = 0;
    for (int bt = 30; bt >= 0; bt--) begin
      cand = z | (64'd1 << bt);
      p = mq30(mq30(mq30(cand, cand), mq30(cand, cand)), cand);
      if (cand <= (64'd1 << 30) && p <= x2) z = cand;
    end
    return (mq30(x2, z) + (64'd1 << 13)) >> 14;
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > 65536) return 65536;
    return v;
  endfunction

  function automatic logic [7:0] unit_to_byte(longint v);
    return 8'((clamp_unit(v) * 255 + 32768) >> 16);
  endfunction

  function automatic longint metallic_root(longint dmax, longint smax);
    longint b, d;
    if (smax * 25 < 65536) return 0;   // dark specular: dielectric
    b = round_div(dmax * (65536 - smax) * 25, longint'(24) * 65536) + smax - 5243;
    d = b * b - (longint'(4) << 32) / 625 + (4 * smax * 65536) / 25;
    if (d < 0) return 0;
    return clamp_unit(round_div((int_sqrt(d) - b) * 25, 2));
  endfunction

  function automatic pixel_t convert_texel(texel_t t);
    pixel_t px;
    longint dl [3], sl [3];
    logic [7:0] dbyte [3], sbyte [3];
    longint dmax, smax, m, dterm, sterm, alpha, gloss;
    logic [7:0] res [3];
    dbyte = '{t.dr, t.dg, t.db};
    sbyte = '{t.sr, t.sg, t.sb};
    for (int i = 0; i < 3; i++) begin
      dl[i] = (srgb_to_lin[dbyte[i]] * factor[i] + 16384) / 32768;
      sl[i] = (srgb_to_lin[sbyte[i]] * factor[4 + i] + 16384) / 32768;
    end
    dmax = dl[0] > dl[1] ? dl[0] : dl[1];
    dmax = dmax > dl[2] ? dmax : dl[2];
    smax = sl[0] > sl[1] ? sl[0] : sl[1];
    smax = smax > sl[2] ? smax : sl[2];
    m = metallic_root(dmax, smax);
    for (int i = 0; i < 3; i++) begin
      // full metallic: drop the diffuse estimate altogether
      dterm = 0;
      if (m != 65536)
        dterm = round_div(dl[i] * (65536 - smax) * 25 * (65536 + m),
                          longint'(24) << 32);
      sterm = round_div((sl[i] * 25 - (65536 - m)) * m, longint'(25) * 65536);
      res[i] = unit_to_byte(dterm + sterm);
    end
    px.br = res[0];
    px.bg = res[1];
    px.bb = res[2];
    alpha = (longint'(t.da) * factor[REG_DIFF_A] + 16384) >> 15;
    px.ba = alpha > 255 ? 8'd255 : 8'(alpha);
    px.occ = 8'd255;
    gloss = (longint'(t.gl) * factor[REG_GLOSS] * 2 + 127) / 255;
    px.rough = unit_to_byte(65536 - gloss);
    px.metal = unit_to_byte(m);
    return px;
  endfunction

  // ---------------------------------------------------------------- drivers
  // valid stays high between back-to-back items; drain drops it
  task automatic send_texel(texel_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_diffuse_red   <= t.dr;
    in_diffuse_green <= t.dg;
    in_diffuse_blue  <= t.db;
    in_diffuse_alpha <= t.da;
    in_spec_red      <= t.sr;
    in_spec_green    <= t.sg;
    in_spec_blue     <= t.sb;
    in_gloss_byte    <= t.gl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(convert_texel(t));
    @(negedge clk);
  endtask

  task automatic write_factor(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_REGS) factor[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for the pipeline to empty before touching the factors
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  function automatic texel_t random_texel();
    texel_t t;
    t.dr = $urandom; t.dg = $urandom; t.db = $urandom; t.da = $urandom;
    t.sr = $urandom; t.sg = $urandom; t.sb = $urandom; t.gl = $urandom;
    // bias part of the specular toward bright, near-grey values (metallic side)
    if ($urandom_range(3) == 0) begin
      t.sr = $urandom_range(255, 180);
      t.sg = $urandom_range(255, 180);
      t.sb = $urandom_range(255, 180);
    end
    return t;
  endfunction

  function automatic texel_t uniform_texel(logic [7:0] d, logic [7:0] s, logic [7:0] g);
    texel_t t;
    t = '{d, d, d, d, s, s, s, g};
    return t;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel at %0t", $time);
      end else begin
        want = pending_pixels.pop_front();
        if (want.br !== out_base_red || want.bg !== out_base_green ||
            want.bb !== out_base_blue || want.ba !== out_base_alpha ||
            want.occ !== out_occlusion_out || want.rough !== out_roughness_out ||
            want.metal !== out_metallic_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch at %0t: exp %0d %0d %0d %0d %0d %0d %0d",
                      " got %0d %0d %0d %0d %0d %0d %0d"},
                     $time, want.br, want.bg, want.bb, want.ba, want.occ, want.rough,
                     want.metal, out_base_red, out_base_green, out_base_blue,
                     out_base_alpha, out_occlusion_out, out_roughness_out,
                     out_metallic_out);
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_output) out_ready <= 1'b0;
    else out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // watchdog: count cycles where nothing moves
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n || hold_output)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("specgloss_to_metalrough_pixel verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed;
    logic [7:0] edges [6] = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
    texel_t t;
    // absent images: all-255 texels, full metallic
    send_texel(uniform_texel(8'd255, 8'd255, 8'd255));
    send_texel(uniform_texel(8'd0, 8'd0, 8'd0));
    // dark specular below 0.04 gives metallic zero
    send_texel(uniform_texel(8'd200, 8'd50, 8'd128));
    foreach (edges[i]) send_texel(uniform_texel(edges[i], edges[5 - i], edges[i]));
    t = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd1};
    send_texel(t);
    t = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd10, 8'd11, 8'd255, 8'd254};
    send_texel(t);
    t = '{8'd56, 8'd56, 8'd56, 8'd200, 8'd255, 8'd230, 8'd200, 8'd128};
    send_texel(t);
    drain();
  endtask

  task automatic test_factors;
    logic [15:0] pick [5] = '{16'd0, 16'd1, 16'd16384, 16'd32767, 16'd32768};
    // extremes of every factor, then random settings; plus an out-of-range index
    for (int s = 0; s < 6; s++) begin
      for (int r = 0; r < NUM_REGS; r++)
        write_factor(8'(r), s < 5 ? pick[s] : 16'($urandom_range(32768)));
      write_factor(8'($urandom_range(255, CFG_BAD)), 16'($urandom));
      for (int n = 0; n < 20; n++) send_texel(random_texel());
      drain();
    end
    // factors above 1.0: saturation of alpha and the clamps
    for (int r = 0; r < NUM_REGS; r++) write_factor(8'(r), 16'hFFFF);
    for (int n = 0; n < 20; n++) send_texel(random_texel());
    send_texel(uniform_texel(8'd255, 8'd255, 8'd255));
    drain();
    for (int r = 0; r < NUM_REGS; r++) write_factor(8'(r), FAC_RESET);
  endtask

  task automatic test_random_phases;
    int sidle [4] = '{0, 71, 0, 37};
    int rstall [4] = '{0, 0, 71, 37};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = sidle[ph];
      recv_stall_pct = rstall[ph];
      for (int n = 0; n < 285; n++) send_texel(random_texel());
      drain();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // hold the output long enough for the pipeline to fill and stall the input
  task automatic test_backpressure;
    fork
      begin
        hold_output = 1'b1;
        repeat (80) @(negedge clk);
        hold_output = 1'b0;
      end
      for (int n = 0; n < 60; n++) send_texel(random_texel());
    join
    drain();
  endtask

  initial begin
    mismatches = 0; idle_cycles = 0; timed_out = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_output = 0;
    for (int c = 0; c < 256; c++) srgb_to_lin[c] = linearise(c);
    for (int r = 0; r < NUM_REGS; r++) factor[r] = FAC_RESET;
    rst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0;
    cfg_index = '0; cfg_data = '0;
    in_diffuse_red = '0; in_diffuse_green = '0; in_diffuse_blue = '0;
    in_diffuse_alpha = '0; in_spec_red = '0; in_spec_green = '0;
    in_spec_blue = '0; in_gloss_byte = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_factors();
    test_random_phases();
    test_backpressure();
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("specgloss_to_metalrough_pixel verification clean");
    else
      $display("specgloss_to_metalrough_pixel verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sgmr_pkg.sv
rtl/sgmr_front.sv
rtl/sgmr_sqrt.sv
rtl/sgmr_metal.sv
rtl/sgmr_blend.sv
rtl/specgloss_to_metalrough_pixel.sv
sim/tb_specgloss_to_metalrough_pixel.sv
